// File: hw/rtl/modular_exponentiation_macros.svh
// Assertion macros for the checker file of the modular exponentiation block.
`ifndef MODULAR_EXPONENTIATION_MACROS_SVH
`define MODULAR_EXPONENTIATION_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ME_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ME_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/me_pkg.sv
// Shared constants and types of the modular exponentiation block.
package me_pkg;

    localparam int unsigned OPERAND_BITS_DEF = 31;

    localparam logic [63:0] MODULUS_RESET = 64'd467;

    typedef enum logic
    {
        OP_REDUCE = 1'b0,
        OP_MULT   = 1'b1
    } me_op_t;

    typedef struct packed
    {
        logic   start;
        me_op_t op;
    } me_mul_cmd_t;

endpackage

// File: hw/rtl/me_req_if.sv
// Request channel: base and exponent with valid/ready handshake.
interface me_req_if
    import me_pkg::*;
#(
    parameter int unsigned W = OPERAND_BITS_DEF
);
    logic         valid;
    logic         ready;
    logic [W-1:0] base;
    logic [W-1:0] exponent;

    modport source (output valid, output base, output exponent, input ready);
    modport sink   (input valid, input base, input exponent, output ready);
endinterface

// File: hw/rtl/me_rsp_if.sv
// Response channel: power with valid/ready handshake.
interface me_rsp_if
    import me_pkg::*;
#(
    parameter int unsigned W = OPERAND_BITS_DEF
);
    logic         valid;
    logic         ready;
    logic [W-1:0] power;

    modport source (output valid, output power, input ready);
    modport sink   (input valid, input power, output ready);
endinterface

// File: hw/rtl/me_modmul.sv
// Bit-serial modular multiplier and reducer, one multiplier bit per cycle.
module me_modmul
    import me_pkg::*;
#(
    parameter int unsigned W = OPERAND_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  me_mul_cmd_t  cmd,
    input  logic [W-1:0] x,
    input  logic [W-1:0] y,
    input  logic [W-1:0] m,
    output logic         done,
    output logic [W-1:0] result
);
    localparam int unsigned CNT_W = $clog2(W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    me_op_t           op_reg;
    logic [W-1:0]     x_reg;
    logic [W-1:0]     y_reg;
    logic [W-1:0]     acc_reg;

    logic             ybit;
    logic [W:0]       dbl;
    logic [W-1:0]     s1;
    logic [W:0]       sum;
    logic [W-1:0]     s2;
    logic [W-1:0]     acc_next;

    // Double the accumulator (shifting in the next bit when reducing), then
    // conditionally add x; each step stays below 2m so one subtract reduces it.
    always_comb
    begin
        ybit     = y_reg[W-1];
        dbl      = {acc_reg, (op_reg == OP_REDUCE) & ybit};
        s1       = (dbl >= {1'b0, m}) ? W'(dbl - {1'b0, m}) : dbl[W-1:0];
        sum      = {1'b0, s1} + {1'b0, x_reg};
        s2       = (sum >= {1'b0, m}) ? W'(sum - {1'b0, m}) : sum[W-1:0];
        acc_next = ((op_reg == OP_MULT) && ybit) ? s2 : s1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (cmd.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(W - 1);
        end
        else if (busy_reg)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            busy_reg <= (cnt_reg != '0);
            done_reg <= (cnt_reg == '0);
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            op_reg  <= cmd.op;
            x_reg   <= x;
            y_reg   <= y;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            y_reg   <= {y_reg[W-2:0], 1'b0};
        end
    end

    assign done   = done_reg;
    assign result = acc_reg;

endmodule

// File: hw/rtl/modular_exponentiation.sv
// Top level: modular exponentiation by right-to-left square-and-multiply.
//
// Usage:
//   req  carries base and exponent; an item is taken when req.valid and
//        req.ready are both high. Only one item is in work at a time.
//   rsp  carries power = base ** exponent mod modulus (1 when exponent is
//        zero); it is held in an output register until rsp.ready takes it.
//   cfg_we / cfg_wdata write the modulus; write only while idle. A modulus
//        of zero acts as one. Reset loads 467.
// Cost: one bit-serial multiplier does every reduction and product, one
//   multiplier bit per cycle. The base reduction costs one operation, and
//   each exponent bit below its highest set bit costs a square plus one
//   multiply when the bit is set; the highest set bit costs one multiply.
// Items: the next item is taken once the previous result has been moved
//   into the output register.
// Reset: clears the sequencer and the output valid, restores the modulus.
// Stall: a finished result waits in the output register; if it is still
//   there when the next result is ready, hold the sequencer until it drains.
module modular_exponentiation
    import me_pkg::*;
#(
    parameter int unsigned OPERAND_BITS = OPERAND_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [OPERAND_BITS-1:0] cfg_wdata,
    me_req_if.sink                  req,
    me_rsp_if.source                rsp
);
    localparam int unsigned W = OPERAND_BITS;
    localparam logic [W-1:0] ONE = {{(W-1){1'b0}}, 1'b1};

    // One-hot sequencer states.
    typedef enum logic [5:0]
    {
        S_IDLE   = 6'b000001,
        S_REDUCE = 6'b000010,
        S_SCAN   = 6'b000100,
        S_MULT   = 6'b001000,
        S_SQUARE = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    state_t       state_reg,  state_next;
    logic [W-1:0] modulus_reg;
    logic [W-1:0] e_reg,      e_next;
    logic [W-1:0] r_reg,      r_next;
    logic [W-1:0] sq_reg,     sq_next;
    logic         out_valid_reg;
    logic [W-1:0] power_reg;

    logic [W-1:0] m_eff;
    me_mul_cmd_t  mul_cmd;
    logic [W-1:0] mul_x;
    logic [W-1:0] mul_y;
    logic         mul_done;
    logic [W-1:0] mul_res;
    logic         out_load;

    // Modulus zero behaves as modulus one.
    assign m_eff = (modulus_reg == '0) ? ONE : modulus_reg;

    me_modmul #(.W(W)) u_modmul
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (mul_cmd),
        .x      (mul_x),
        .y      (mul_y),
        .m      (m_eff),
        .done   (mul_done),
        .result (mul_res)
    );

    always_comb
    begin
        state_next    = state_reg;
        e_next        = e_reg;
        r_next        = r_reg;
        sq_next       = sq_reg;
        mul_cmd.start = 1'b0;
        mul_cmd.op    = OP_MULT;
        mul_x         = sq_reg;
        mul_y         = sq_reg;
        out_load      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                // Take the item and start reducing the base by the modulus.
                if (req.valid)
                begin
                    e_next        = req.exponent;
                    r_next        = ONE;
                    mul_cmd.start = 1'b1;
                    mul_cmd.op    = OP_REDUCE;
                    mul_y         = req.base;
                    state_next    = S_REDUCE;
                end
            end
            S_REDUCE:
            begin
                if (mul_done)
                begin
                    sq_next    = mul_res;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // Finish once the exponent is used up; otherwise multiply on a
                // set bit or go straight to squaring on a clear one.
                if (e_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else if (e_reg[0])
                begin
                    mul_cmd.start = 1'b1;
                    mul_x         = r_reg;
                    state_next    = S_MULT;
                end
                else
                begin
                    mul_cmd.start = 1'b1;
                    state_next    = S_SQUARE;
                end
            end
            S_MULT:
            begin
                if (mul_done)
                begin
                    r_next = mul_res;
                    // Skip the square after the last set bit.
                    if (e_reg[W-1:1] == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        mul_cmd.start = 1'b1;
                        state_next    = S_SQUARE;
                    end
                end
            end
            S_SQUARE:
            begin
                if (mul_done)
                begin
                    sq_next    = mul_res;
                    e_next     = {1'b0, e_reg[W-1:1]};
                    state_next = S_SCAN;
                end
            end
            S_DONE:
            begin
                // Hold until the output register is free or drains this cycle.
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            modulus_reg   <= MODULUS_RESET[W-1:0];
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                modulus_reg <= cfg_wdata;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        e_reg  <= e_next;
        r_reg  <= r_next;
        sq_reg <= sq_next;
        if (out_load)
        begin
            power_reg <= r_reg;
        end
    end

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.power = power_reg;

endmodule

// File: hw/rtl/me_checker.sv
// Port-level checker for the modular exponentiation block, with its bind.
`include "modular_exponentiation_macros.svh"

module me_checker
    import me_pkg::*;
#(
    parameter int unsigned W = OPERAND_BITS_DEF
)
(
    input logic         clk,
    input logic         rst_n,
    input logic         req_valid,
    input logic         req_ready,
    input logic         rsp_valid,
    input logic         rsp_ready,
    input logic [W-1:0] power
);

    // A stalled result stays valid and unchanged.
    `ME_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(power), "result changed while stalled")

    // One item at a time: the request side closes right after an item is taken.
    `ME_ASSERT_NXT(a_one_in_flight, req_valid && req_ready, !req_ready, "second item taken while busy")

    // No result can appear in the cycle after an item is taken.
    `ME_ASSERT_NXT(a_no_early_result, req_valid && req_ready, !$rose(rsp_valid), "result too early")

    // Every result is below the modulus or is one, so never all ones.
    `ME_ASSERT_IMP(a_power_range, rsp_valid, power != {W{1'b1}}, "result out of range")

endmodule

bind modular_exponentiation me_checker #(.W(OPERAND_BITS)) u_me_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .power     (rsp.power)
);
